[hw/rtl/spq_pkg.sv]
// shared types and codes for the sorted priority queue
package spq_pkg;

   localparam int IdWidth       = 16;
   localparam int PriorityWidth = 8;
   localparam int OccWidth      = 4;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_REMOVE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [IdWidth-1:0]       id;
      logic [PriorityWidth-1:0] prio;
   } entry_type;

   // per cell control from the queue controller
   typedef struct packed {
      logic insert;    // an insert is applied this cycle
      logic remove;    // a removal is applied this cycle
      logic occupied;  // cell holds a live entry
      logic at_tail;   // cell is the first free slot
   } cell_ctrl_type;

endpackage

[hw/rtl/spq_cell.sv]
// one storage cell of the sorted queue chain
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  entry_type     left_entry,
   input  logic          left_greater,
   input  entry_type     right_entry,
   output logic          greater,
   output entry_type     entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // live entry that must move behind the new one
   assign greater = ctrl.occupied && (entry_ff.prio > new_entry.prio);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (left_greater) begin
            entry_in = left_entry;
         end else if (greater || ctrl.at_tail) begin
            entry_in = new_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[hw/rtl/sorted_priority_queue.sv]
// sorted priority queue built as a chain of compare and shift cells
//
//   channel   direction  payload
//   req_      in         kind, new_id, new_priority
//   rsp_      out        status, out_id, out_priority, occupancy
//
// one request is taken per cycle unless a held response stalls it; the whole operation finishes in the cycle
// of acceptance, every cell comparing against the new priority in parallel
// the response appears in the cycle after acceptance, in an output register
// a new request is taken when no response is held or the held response is taken in the same cycle
// reset clears the entry count and the response valid; cell contents are
// left as they are and are only read below the count
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [IdWidth-1:0]       req_new_id,
   input  logic [PriorityWidth-1:0] req_new_priority,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic [IdWidth-1:0]       rsp_out_id,
   output logic [PriorityWidth-1:0] rsp_out_priority,
   output logic [OccWidth-1:0]      rsp_occupancy
);

   localparam int CW = $clog2(DEPTH + 1);

   // entry count
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   // response register
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   entry_type                out_entry_ff;
   entry_type                out_entry_in;
   logic [OccWidth-1:0]      occ_ff;
   logic [OccWidth-1:0]      occ_in;

   logic          fire;
   logic          is_insert;
   logic          full;
   logic          empty;
   logic          insert_ok;
   logic          remove_ok;
   entry_type     new_entry;
   logic [CW+OccWidth-1:0] count_ext;

   // chain signals
   entry_type     cell_entry   [DEPTH];
   logic          cell_greater [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign is_insert = (kind_type'(req_kind) == KIND_INSERT);
   assign full      = (count_ff >= CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign insert_ok = fire && is_insert && !full;
   assign remove_ok = fire && !is_insert && !empty;

   assign new_entry.id   = req_new_id;
   assign new_entry.prio = req_new_priority;

   // cell row: each cell sees its neighbors and the greater flag on its left
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     left_entry;
      entry_type     right_entry;
      logic          left_greater;

      assign ctrl.insert   = insert_ok;
      assign ctrl.remove   = remove_ok;
      assign ctrl.occupied = (CW'(i) < count_ff);
      assign ctrl.at_tail  = (CW'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_entry   = new_entry;
         assign left_greater = 1'b0;
      end else begin : g_body
         assign left_entry   = cell_entry[i-1];
         assign left_greater = cell_greater[i-1];
      end

      // the last cell has no right neighbor; what it takes is beyond the count
      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl),
         .new_entry    (new_entry),
         .left_entry   (left_entry),
         .left_greater (left_greater),
         .right_entry  (right_entry),
         .greater      (cell_greater[i]),
         .entry        (cell_entry[i])
      );
   end

   // count update and response build
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      out_entry_in = out_entry_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (insert_ok) begin
         count_in = count_ff + CW'(1);
      end else if (remove_ok) begin
         count_in = count_ff - CW'(1);
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         out_entry_in = '0;
         if (is_insert) begin
            status_in = full ? STATUS_FULL : STATUS_DONE;
         end else if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in    = STATUS_DONE;
            out_entry_in = cell_entry[0];
         end
      end
   end

   // occupancy reports the low bits of the count after the request
   assign count_ext = {{OccWidth{1'b0}}, count_in};
   assign occ_in    = fire ? count_ext[OccWidth-1:0] : occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      out_entry_ff <= out_entry_in;
      occ_ff       <= occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_entry_ff.id;
   assign rsp_out_priority = out_entry_ff.prio;
   assign rsp_occupancy    = occ_ff;

endmodule

[verif/sorted_priority_queue_test.sv]
// self-checking testbench for the sorted priority queue
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int QueueDepth  = 8;
   localparam int CycleLimit  = 200000;
   localparam int MaxReported = 10;

   // one expected response, in the same shape as the response channel
   typedef struct packed {
      status_type               status;
      logic [IdWidth-1:0]       id;
      logic [PriorityWidth-1:0] prio;
      logic [OccWidth-1:0]      occupancy;
   } response_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_kind         = KIND_INSERT;
   logic [IdWidth-1:0]       req_new_id       = '0;
   logic [PriorityWidth-1:0] req_new_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [1:0]               rsp_status;
   logic [IdWidth-1:0]       rsp_out_id;
   logic [PriorityWidth-1:0] rsp_out_priority;
   logic [OccWidth-1:0]      rsp_occupancy;

   // shadow copy of the queue contents, kept in sorted order
   logic [IdWidth-1:0]       shadow_ids[QueueDepth];
   logic [PriorityWidth-1:0] shadow_priorities[QueueDepth];
   int                       shadow_count = 0;

   response_type pending_responses[$];

   int error_count        = 0;
   int cycle_count        = 0;
   int send_gap_max       = 0;   // longest idle gap before a request
   int ready_gap_max      = 0;   // longest stall before taking a response
   int ready_hold_cycles  = 0;   // one long receiver stall, picked up by the receiver

   sorted_priority_queue #(
      .DEPTH(QueueDepth)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_new_id      (req_new_id),
      .req_new_priority(req_new_priority),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_priority(rsp_out_priority),
      .rsp_occupancy   (rsp_occupancy)
   );

   always #1 clock = ~clock;

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("sorted_priority_queue test failed");
         $finish;
      end
   end

   // apply one request to the shadow queue and return the response it should give
   function automatic response_type predict_queue_response(
      kind_type                 kind,
      logic [IdWidth-1:0]       id,
      logic [PriorityWidth-1:0] prio
   );
      response_type rsp;
      int           pos;
      rsp.status = STATUS_DONE;
      rsp.id     = '0;
      rsp.prio   = '0;
      if (kind == KIND_INSERT) begin
         if (shadow_count >= QueueDepth) begin
            // queue full, the new entry is dropped
            rsp.status = STATUS_FULL;
         end else begin
            // go behind every entry of equal or smaller priority
            pos = 0;
            while (pos < shadow_count && shadow_priorities[pos] <= prio) pos++;
            for (int k = shadow_count; k > pos; k--) begin
               shadow_ids[k]        = shadow_ids[k-1];
               shadow_priorities[k] = shadow_priorities[k-1];
            end
            shadow_ids[pos]        = id;
            shadow_priorities[pos] = prio;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         rsp.status = STATUS_EMPTY;
      end else begin
         // hand out the head, everything else moves forward
         rsp.id   = shadow_ids[0];
         rsp.prio = shadow_priorities[0];
         for (int k = 0; k + 1 < shadow_count; k++) begin
            shadow_ids[k]        = shadow_ids[k+1];
            shadow_priorities[k] = shadow_priorities[k+1];
         end
         shadow_count--;
      end
      rsp.occupancy = shadow_count[OccWidth-1:0];
      return rsp;
   endfunction

   // full-range priorities half the time, with ties and extremes mixed in
   function automatic logic [PriorityWidth-1:0] draw_priority();
      case ($urandom_range(3, 0))
         0:       return PriorityWidth'($urandom_range(3, 0));
         1:       return $urandom_range(1, 0) ? 8'hff : 8'h00;
         default: return PriorityWidth'($urandom_range(255, 0));
      endcase
   endfunction

   // offer one request after a random gap, predict its response once accepted
   task automatic send_request(
      kind_type                 kind,
      logic [IdWidth-1:0]       id,
      logic [PriorityWidth-1:0] prio
   );
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_new_id       <= id;
      req_new_priority <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_responses.push_back(predict_queue_response(kind, id, prio));
   endtask

   // drop valid so a waiting sender does not offer the last request again
   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_for_responses();
      idle_sender();
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_request(int insert_percent);
      if ($urandom_range(99, 0) < insert_percent) begin
         send_request(KIND_INSERT, IdWidth'($urandom_range(65535, 0)), draw_priority());
      end else begin
         send_request(KIND_REMOVE, IdWidth'($urandom_range(65535, 0)), draw_priority());
      end
   endtask

   task automatic record_failure(string what, logic [31:0] want, logic [31:0] got);
      error_count++;
      if (error_count <= MaxReported) begin
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
      end
   endtask

   // receiver: random stall per response, plus one long hold when asked
   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(ready_gap_max, 0);
         @(negedge clock);
         if (ready_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (ready_hold_cycles) @(negedge clock);
            ready_hold_cycles = 0;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // compare every taken response with the oldest prediction
   always @(posedge clock) begin : check_responses
      response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_responses.size() == 0) begin
            record_failure("response with no request outstanding", '0, 32'(rsp_status));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_status !== want.status)
               record_failure("status", 32'(want.status), 32'(rsp_status));
            if (rsp_out_id !== want.id)
               record_failure("out_id", 32'(want.id), 32'(rsp_out_id));
            if (rsp_out_priority !== want.prio)
               record_failure("out_priority", 32'(want.prio), 32'(rsp_out_priority));
            if (rsp_occupancy !== want.occupancy)
               record_failure("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         end
      end
   end

   // empty removal, fill with ties and extremes, overflow, drain past empty
   task automatic test_boundaries();
      send_gap_max  = 14;
      ready_gap_max = 14;
      send_request(KIND_REMOVE, 16'hffff, 8'hff);
      send_request(KIND_INSERT, 16'h0000, 8'hff);
      send_request(KIND_INSERT, 16'hffff, 8'h00);
      send_request(KIND_INSERT, 16'h1234, 8'h80);
      send_request(KIND_INSERT, 16'h5678, 8'h80);   // tie keeps arrival order
      send_request(KIND_INSERT, 16'h0001, 8'h00);   // tie with the head
      send_request(KIND_INSERT, 16'hfffe, 8'hff);   // tie with the tail
      send_request(KIND_INSERT, 16'h8000, 8'h7f);
      send_request(KIND_INSERT, 16'h7fff, 8'h80);
      send_request(KIND_INSERT, 16'hbeef, 8'h01);   // full, dropped
      repeat (QueueDepth)
         send_request(KIND_REMOVE, IdWidth'($urandom_range(65535, 0)), draw_priority());
      send_request(KIND_REMOVE, 16'h0000, 8'h00);   // empty again
      send_request(KIND_INSERT, 16'haaaa, 8'h55);
      send_request(KIND_REMOVE, 16'h5555, 8'haa);
   endtask

   // receiver holds off for a long time while requests keep coming
   task automatic test_output_backpressure();
      wait_for_responses();
      send_gap_max      = 0;
      ready_gap_max     = 0;
      ready_hold_cycles = 60;
      repeat (24) send_random_request(60);
      wait_for_responses();
   endtask

   // whole fill and drain rounds, at times overshooting both ends
   task automatic test_fill_and_drain_rounds();
      for (int round = 0; round < 10; round++) begin
         send_gap_max  = (round % 3 == 2) ? 0 : 14;
         ready_gap_max = (round % 4 == 3) ? 0 : 14;
         repeat (QueueDepth + $urandom_range(2, 0))
            send_request(KIND_INSERT, IdWidth'($urandom_range(65535, 0)), draw_priority());
         repeat (QueueDepth + $urandom_range(2, 0))
            send_request(KIND_REMOVE, IdWidth'($urandom_range(65535, 0)), draw_priority());
      end
   endtask

   // random mix in chunks, each with its own insert bias and idling
   task automatic test_random_mix();
      int bias;
      for (int chunk = 0; chunk < 6; chunk++) begin
         bias          = 25 * $urandom_range(3, 1);
         send_gap_max  = $urandom_range(1, 0) ? 14 : 0;
         ready_gap_max = $urandom_range(1, 0) ? 14 : 0;
         repeat (50) send_random_request(bias);
      end
   endtask

   // back to back traffic with no idling on either side
   task automatic test_back_to_back();
      send_gap_max  = 0;
      ready_gap_max = 0;
      repeat (150) send_random_request(50);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_boundaries();
      test_output_backpressure();
      test_fill_and_drain_rounds();
      test_random_mix();
      test_back_to_back();

      // let the last responses arrive, then watch for strays
      wait_for_responses();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_priority_queue test passed");
      end else begin
         $display("sorted_priority_queue test failed");
      end
      $finish;
   end

endmodule
